FILE: rtl/line_clip_cohen_sutherland_macros.svh
// ----------------------------------------------------------------------------
// line clipper assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_CLIP_COHEN_SUTHERLAND_MACROS_SVH
`define LINE_CLIP_COHEN_SUTHERLAND_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LCS_CHECK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LCS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types, widths, codes and helpers of the line clipper
// ----------------------------------------------------------------------------
package lcs_pkg;

	// coordinate width, signed two's complement
	localparam int COORD_WIDTH = 16;
	// endpoint differences carry one extra bit
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	// full width product of two difference magnitudes
	localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
	// quotient bits resolved per divider cycle
	localparam int DIV_STEPS = 2;
	// clip guard
	localparam int MAX_CLIPS = 4;
	localparam int CLIP_CNT_WIDTH = $clog2(MAX_CLIPS + 1);
	localparam int CFG_IDX_WIDTH = 2;

	localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	// window reset values, saturated to the coordinate range
	localparam longint WIN_LO_RST = (COORD_MIN > -2048) ? COORD_MIN : -2048;
	localparam longint WIN_HI_RST = (COORD_MAX < 2048) ? COORD_MAX : 2048;

	// outcode bits
	localparam logic [3:0] CODE_LEFT   = 4'b0001;
	localparam logic [3:0] CODE_RIGHT  = 4'b0010;
	localparam logic [3:0] CODE_BOTTOM = 4'b0100;
	localparam logic [3:0] CODE_TOP    = 4'b1000;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_MIN = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_X_MAX = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_Y_MAX = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} lcs_in_t;

	typedef struct packed {
		logic   accepted;
		coord_t out_ax;
		coord_t out_ay;
		coord_t out_bx;
		coord_t out_by;
	} lcs_out_t;

	typedef struct packed {
		coord_t x_min;
		coord_t y_min;
		coord_t x_max;
		coord_t y_max;
	} win_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic setup;
		logic div_start;
		logic update;
		logic load_out;
		logic acc;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_win;
		logic reject;
		logic div_done;
	} sts_t;

	function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
		logic [3:0] c;
		c = '0;
		if (x < w.x_min)
			c = c | CODE_LEFT;
		else if (x > w.x_max)
			c = c | CODE_RIGHT;
		if (y < w.y_min)
			c = c | CODE_BOTTOM;
		else if (y > w.y_max)
			c = c | CODE_TOP;
		return c;
	endfunction

endpackage

FILE: rtl/lcs_div.sv
// ----------------------------------------------------------------------------
// lcs_div
// iterative restoring divider, unsigned, DIV_STEPS quotient bits per cycle
// ----------------------------------------------------------------------------
module lcs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lcs_pkg::PROD_WIDTH-1:0]    dividend,
	input  logic [lcs_pkg::DIFF_WIDTH-1:0]    divisor,
	output logic                              done,
	output logic [lcs_pkg::PROD_WIDTH-1:0]    quotient
);

	localparam int D    = lcs_pkg::DIFF_WIDTH;
	localparam int P    = lcs_pkg::PROD_WIDTH;
	localparam int ITER = P / lcs_pkg::DIV_STEPS;
	localparam int CW   = $clog2(ITER);
	localparam logic [CW-1:0] LAST = CW'(ITER - 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  div_q;
	logic [P-1:0]  work_q;
	logic [D-1:0]  rem_n;
	logic [P-1:0]  work_n;

	// dividend bits shift out at the top, quotient bits shift in at the bottom
	always_comb begin
		logic [D:0]   r;
		logic [P-1:0] w;
		r = {1'b0, rem_q};
		w = work_q;
		for (int i = 0; i < lcs_pkg::DIV_STEPS; i++) begin
			r = {r[D-1:0], w[P-1]};
			w = {w[P-2:0], 1'b0};
			if (r >= {1'b0, div_q}) begin
				r    = r - {1'b0, div_q};
				w[0] = 1'b1;
			end
		end
		rem_n  = r[D-1:0];
		work_n = w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign done     = busy_q && (cnt_q == LAST);
	assign quotient = work_q;

endmodule

FILE: rtl/lcs_dp.sv
// ----------------------------------------------------------------------------
// lcs_dp
// endpoint registers, outcodes, edge setup, multiplier, divider, result register
// ----------------------------------------------------------------------------
module lcs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::lcs_in_t   in_data,
	input  lcs_pkg::win_t      win,
	input  lcs_pkg::cmd_t      cmd,
	output lcs_pkg::sts_t      sts,
	output lcs_pkg::lcs_out_t  out_data
);

	localparam int W = lcs_pkg::COORD_WIDTH;
	localparam int D = lcs_pkg::DIFF_WIDTH;
	localparam int P = lcs_pkg::PROD_WIDTH;

	lcs_pkg::coord_t   x1_q, y1_q, x2_q, y2_q;
	lcs_pkg::coord_t   edge_q, base_q;
	logic              first_q, horiz_q;
	logic [D-1:0]      a_q, b_q, d_q;
	logic              neg_q, dz_q;
	lcs_pkg::lcs_out_t out_q;

	logic [3:0]        c1, c2, co;
	logic [D-1:0]      ma, mb, md;
	logic [P-1:0]      prod;
	logic              div_done;
	logic [P-1:0]      quot;
	logic              q_over;
	logic [D-1:0]      qc;
	logic [W+1:0]      qe, sq, sum;
	lcs_pkg::coord_t   clipped;

	function automatic logic [D-1:0] sx(lcs_pkg::coord_t v);
		return {v[W-1], v};
	endfunction

	function automatic logic [D-1:0] absd(logic [D-1:0] v);
		return v[D-1] ? (~v + D'(1)) : v;
	endfunction

	assign c1 = lcs_pkg::outcode(x1_q, y1_q, win);
	assign c2 = lcs_pkg::outcode(x2_q, y2_q, win);
	assign co = (c1 != 4'b0000) ? c1 : c2;

	assign sts.in_win   = (c1 == 4'b0000) && (c2 == 4'b0000);
	assign sts.reject   = (c1 & c2) != 4'b0000;
	assign sts.div_done = div_done;

	// magnitudes and full width product
	assign ma   = absd(a_q);
	assign mb   = absd(b_q);
	assign md   = absd(d_q);
	assign prod = P'(ma) * P'(mb);

	lcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod),
		.divisor  (md),
		.done     (div_done),
		.quotient (quot)
	);

	// clamp quotient magnitude at 2^W, anything beyond saturates the same way
	assign q_over = (|quot[P-1:W+1]) || (quot[W] && (|quot[W-1:0]));
	assign qc     = q_over ? {1'b1, {W{1'b0}}} : quot[W:0];
	assign qe     = dz_q ? '0 : {1'b0, qc};
	assign sq     = neg_q ? (~qe + (W+2)'(1)) : qe;
	assign sum    = {{2{base_q[W-1]}}, base_q} + sq;

	always_comb begin
		if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111)
			clipped = sum[W-1:0];
		else if (sum[W+1])
			clipped = {1'b1, {(W-1){1'b0}}};
		else
			clipped = {1'b0, {(W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x1_q <= in_data.ax;
			y1_q <= in_data.ay;
			x2_q <= in_data.bx;
			y2_q <= in_data.by;
		end else if (cmd.update) begin
			if (first_q) begin
				x1_q <= horiz_q ? clipped : edge_q;
				y1_q <= horiz_q ? edge_q : clipped;
			end else begin
				x2_q <= horiz_q ? clipped : edge_q;
				y2_q <= horiz_q ? edge_q : clipped;
			end
		end

		// edge choice: top, bottom, right, left
		if (cmd.setup) begin
			first_q <= (c1 != 4'b0000);
			if ((co & lcs_pkg::CODE_TOP) != 4'b0000) begin
				horiz_q <= 1'b1;
				edge_q  <= win.y_max;
				base_q  <= x1_q;
				a_q     <= sx(x2_q) - sx(x1_q);
				b_q     <= sx(win.y_max) - sx(y1_q);
				d_q     <= sx(y2_q) - sx(y1_q);
			end else if ((co & lcs_pkg::CODE_BOTTOM) != 4'b0000) begin
				horiz_q <= 1'b1;
				edge_q  <= win.y_min;
				base_q  <= x1_q;
				a_q     <= sx(x2_q) - sx(x1_q);
				b_q     <= sx(win.y_min) - sx(y1_q);
				d_q     <= sx(y2_q) - sx(y1_q);
			end else if ((co & lcs_pkg::CODE_RIGHT) != 4'b0000) begin
				horiz_q <= 1'b0;
				edge_q  <= win.x_max;
				base_q  <= y1_q;
				a_q     <= sx(y2_q) - sx(y1_q);
				b_q     <= sx(win.x_max) - sx(x1_q);
				d_q     <= sx(x2_q) - sx(x1_q);
			end else begin
				horiz_q <= 1'b0;
				edge_q  <= win.x_min;
				base_q  <= y1_q;
				a_q     <= sx(y2_q) - sx(y1_q);
				b_q     <= sx(win.x_min) - sx(x1_q);
				d_q     <= sx(x2_q) - sx(x1_q);
			end
		end

		if (cmd.div_start) begin
			neg_q <= a_q[D-1] ^ b_q[D-1] ^ d_q[D-1];
			dz_q  <= (d_q == '0);
		end

		if (cmd.load_out) begin
			out_q.accepted <= cmd.acc;
			out_q.out_ax   <= cmd.acc ? x1_q : '0;
			out_q.out_ay   <= cmd.acc ? y1_q : '0;
			out_q.out_bx   <= cmd.acc ? x2_q : '0;
			out_q.out_by   <= cmd.acc ? y2_q : '0;
		end
	end

	assign out_data = out_q;

endmodule

FILE: rtl/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// sequencer: trivial tests, clip iterations, result handoff
// ----------------------------------------------------------------------------
module lcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lcs_pkg::sts_t sts,
	output lcs_pkg::cmd_t cmd
);

	localparam int CNW = lcs_pkg::CLIP_CNT_WIDTH;
	localparam logic [CNW-1:0] CLIP_LIMIT = CNW'(lcs_pkg::MAX_CLIPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t         state_q;
	logic [CNW-1:0] clips_q;
	logic           acc_q;
	logic           out_valid_q;
	logic           give_out;
	logic           do_clip;

	assign give_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign do_clip  = (state_q == ST_EVAL) && !sts.in_win && !sts.reject
		&& (clips_q != CLIP_LIMIT);

	always_comb begin
		cmd.load_in   = (state_q == ST_IDLE) && in_valid;
		cmd.setup     = do_clip;
		cmd.div_start = (state_q == ST_MUL);
		cmd.update    = (state_q == ST_UPDATE);
		cmd.load_out  = give_out;
		cmd.acc       = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clips_q     <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (give_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						clips_q <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.in_win) begin
						acc_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (!do_clip) begin
						acc_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						clips_q <= clips_q + CNW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_EVAL;
				end
				ST_DONE: begin
					if (give_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/line_clip_cohen_sutherland.sv
// ----------------------------------------------------------------------------
// line_clip_cohen_sutherland: segment clipper against a window in registers
// up to 4 clips per segment (MAX_CLIPS); the divider computes the intersection of each clip
// one segment at a time: the input stays stalled until the result moves to its register
// async active-low reset: idle, no result pending, window at +-2048 saturated
// ----------------------------------------------------------------------------
`include "line_clip_cohen_sutherland_macros.svh"

module line_clip_cohen_sutherland (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// segment input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  lcs_pkg::lcs_in_t                       in_data,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output lcs_pkg::lcs_out_t                      out_data,
	// window register writes
	input  logic                                   cfg_we,
	input  logic [lcs_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
	input  lcs_pkg::coord_t                        cfg_data
);

	localparam int W = lcs_pkg::COORD_WIDTH;

	// window registers
	lcs_pkg::win_t win_q;

	// controller <-> datapath
	lcs_pkg::cmd_t cmd;
	lcs_pkg::sts_t sts;

	// window writes land directly, no read-back path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.x_min <= W'(lcs_pkg::WIN_LO_RST);
			win_q.y_min <= W'(lcs_pkg::WIN_LO_RST);
			win_q.x_max <= W'(lcs_pkg::WIN_HI_RST);
			win_q.y_max <= W'(lcs_pkg::WIN_HI_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				lcs_pkg::REG_X_MIN: win_q.x_min <= cfg_data;
				lcs_pkg::REG_Y_MIN: win_q.y_min <= cfg_data;
				lcs_pkg::REG_X_MAX: win_q.x_max <= cfg_data;
				lcs_pkg::REG_Y_MAX: win_q.y_max <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: evaluate codes, then per clip setup, multiply, divide, update;
	// the result waits in its own register so the next segment can enter
	lcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// endpoints, outcodes, intersection arithmetic and result register
	lcs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.win      (win_q),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	// a taken segment keeps the input side stalled while it is worked on
	`LCS_CHECK_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input not stalled after a transaction")

	// rejected segments carry zero endpoints
	`LCS_CHECK_SAME(a_reject_zero, out_valid && !out_data.accepted, out_data.out_ax == '0 && out_data.out_ay == '0 && out_data.out_bx == '0 && out_data.out_by == '0, "rejected result with nonzero endpoints")

	// a fresh result only appears after the block was busy with a segment
	`LCS_CHECK_SAME(a_result_after_work, $rose(out_valid), $past(in_stall), "result appeared without a segment in work")

endmodule

FILE: bench/line_clip_cohen_sutherland_checker.sv
// ----------------------------------------------------------------------------
// line_clip_cohen_sutherland_checker
// watches the segment and result channels and the window register writes,
// clips every accepted segment on its own copy of the window and compares
// each taken result, in order, against the oldest clipped segment
// ----------------------------------------------------------------------------
module line_clip_cohen_sutherland_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  lcs_pkg::lcs_in_t                  in_data,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  lcs_pkg::lcs_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [lcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  lcs_pkg::coord_t                   cfg_data,
	output int                                fail_count,
	output int                                pending,
	output int                                segments_checked,
	output int                                segments_kept
);

	// quotient magnitude ceiling of the model's intersection divide
	localparam longint QUOT_CAP = longint'(1) <<< 41;

	longint            win_x_lo, win_y_lo, win_x_hi, win_y_hi;
	lcs_pkg::lcs_out_t clipped_q[$];
	lcs_pkg::lcs_out_t want;
	int                fails, checked, kept;

	function automatic longint sat_coord(input longint v);
		if (v > lcs_pkg::COORD_MAX)
			return lcs_pkg::COORD_MAX;
		if (v < lcs_pkg::COORD_MIN)
			return lcs_pkg::COORD_MIN;
		return v;
	endfunction

	function automatic logic [3:0] region(input longint x, input longint y);
		logic [3:0] c;
		c = '0;
		if (x < win_x_lo)
			c = c | lcs_pkg::CODE_LEFT;
		else if (x > win_x_hi)
			c = c | lcs_pkg::CODE_RIGHT;
		if (y < win_y_lo)
			c = c | lcs_pkg::CODE_BOTTOM;
		else if (y > win_y_hi)
			c = c | lcs_pkg::CODE_TOP;
		return c;
	endfunction

	// a*b/d truncated toward zero, magnitude capped at QUOT_CAP, zero divisor gives zero
	function automatic longint scaled_ratio(input longint a, input longint b, input longint d);
		longint q;
		logic   neg;
		if (d == 0)
			return 0;
		q = ((a < 0) ? -a : a) * ((b < 0) ? -b : b) / ((d < 0) ? -d : d);
		if (q > QUOT_CAP)
			q = QUOT_CAP;
		neg = ((a < 0) != (b < 0)) != (d < 0);
		return neg ? -q : q;
	endfunction

	function automatic lcs_pkg::lcs_out_t clip_segment(input lcs_pkg::lcs_in_t s);
		longint            x1, y1, x2, y2, x, y;
		logic [3:0]        c1, c2, co;
		logic              hit, first;
		lcs_pkg::lcs_out_t r;
		x1 = longint'(s.ax);
		y1 = longint'(s.ay);
		x2 = longint'(s.bx);
		y2 = longint'(s.by);
		c1 = region(x1, y1);
		c2 = region(x2, y2);
		hit = 1'b0;
		for (int n = 0; n <= lcs_pkg::MAX_CLIPS; n++) begin
			if (c1 == 0 && c2 == 0) begin
				hit = 1'b1;
				break;
			end
			if ((c1 & c2) != 0 || n == lcs_pkg::MAX_CLIPS)
				break;
			first = (c1 != 0);
			co = first ? c1 : c2;
			// edge priority: top, bottom, right, left
			if ((co & lcs_pkg::CODE_TOP) != 0) begin
				y = win_y_hi;
				x = sat_coord(x1 + scaled_ratio(x2 - x1, win_y_hi - y1, y2 - y1));
			end else if ((co & lcs_pkg::CODE_BOTTOM) != 0) begin
				y = win_y_lo;
				x = sat_coord(x1 + scaled_ratio(x2 - x1, win_y_lo - y1, y2 - y1));
			end else if ((co & lcs_pkg::CODE_RIGHT) != 0) begin
				x = win_x_hi;
				y = sat_coord(y1 + scaled_ratio(y2 - y1, win_x_hi - x1, x2 - x1));
			end else begin
				x = win_x_lo;
				y = sat_coord(y1 + scaled_ratio(y2 - y1, win_x_lo - x1, x2 - x1));
			end
			if (first) begin
				x1 = x;
				y1 = y;
				c1 = region(x1, y1);
			end else begin
				x2 = x;
				y2 = y;
				c2 = region(x2, y2);
			end
		end
		r.accepted = hit;
		r.out_ax = hit ? x1[lcs_pkg::COORD_WIDTH-1:0] : '0;
		r.out_ay = hit ? y1[lcs_pkg::COORD_WIDTH-1:0] : '0;
		r.out_bx = hit ? x2[lcs_pkg::COORD_WIDTH-1:0] : '0;
		r.out_by = hit ? y2[lcs_pkg::COORD_WIDTH-1:0] : '0;
		return r;
	endfunction

	function automatic void compare_field(input string field, input longint exp_v,
			input longint got_v);
		if (exp_v != got_v) begin
			fails++;
			$display("%0t: result %0d field %s expected %0d, got %0d",
				$time, checked, field, exp_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_lo = lcs_pkg::WIN_LO_RST;
			win_y_lo = lcs_pkg::WIN_LO_RST;
			win_x_hi = lcs_pkg::WIN_HI_RST;
			win_y_hi = lcs_pkg::WIN_HI_RST;
			clipped_q.delete();
			fails = 0;
			checked = 0;
			kept = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lcs_pkg::REG_X_MIN: win_x_lo = longint'(cfg_data);
					lcs_pkg::REG_Y_MIN: win_y_lo = longint'(cfg_data);
					lcs_pkg::REG_X_MAX: win_x_hi = longint'(cfg_data);
					lcs_pkg::REG_Y_MAX: win_y_hi = longint'(cfg_data);
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				clipped_q = {clipped_q, clip_segment(in_data)};
			if (out_valid && !out_stall) begin
				if (clipped_q.size() == 0) begin
					fails++;
					$display("%0t: result with no segment outstanding, expected none, got %h",
						$time, out_data);
				end else begin
					want = clipped_q.pop_front();
					compare_field("accepted", longint'(want.accepted),
						longint'(out_data.accepted));
					compare_field("out_ax", longint'(want.out_ax), longint'(out_data.out_ax));
					compare_field("out_ay", longint'(want.out_ay), longint'(out_data.out_ay));
					compare_field("out_bx", longint'(want.out_bx), longint'(out_data.out_bx));
					compare_field("out_by", longint'(want.out_by), longint'(out_data.out_by));
					checked++;
					if (want.accepted)
						kept++;
				end
			end
		end
		fail_count <= fails;
		pending <= clipped_q.size();
		segments_checked <= checked;
		segments_kept <= kept;
	end

endmodule

FILE: bench/line_clip_cohen_sutherland_test.sv
// ----------------------------------------------------------------------------
// line_clip_cohen_sutherland_test
// drives segments through the clipper under a series of windows: reset
// default, full range, degenerate, inverted and corner windows plus random
// ones; directed edge cases first, then random segments biased around the
// window; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module line_clip_cohen_sutherland_test;

	// settle margin after a drain, beyond the worst clip latency
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_PER_WINDOW = 125;
	localparam int NUM_WINDOWS = 8;
	// long receiver hold-off, starts after this many results
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 500;
	// coordinate range
	localparam longint COORD_MIN = lcs_pkg::COORD_MIN;
	localparam longint COORD_MAX = lcs_pkg::COORD_MAX;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	lcs_pkg::lcs_in_t                  in_data;
	logic                              out_valid;
	logic                              out_stall;
	lcs_pkg::lcs_out_t                 out_data;
	logic                              cfg_we;
	logic [lcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
	lcs_pkg::coord_t                   cfg_data;

	int fail_count;
	int pending;
	int segments_checked;
	int segments_kept;

	// idle enables for sender and receiver
	logic src_gaps;
	logic snk_gaps;
	// stimulus copy of the current window, used only to aim segments
	longint wx_lo, wy_lo, wx_hi, wy_hi;
	// directed segments
	lcs_pkg::lcs_in_t edge_cases[$];

	line_clip_cohen_sutherland u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	line_clip_cohen_sutherland_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.segments_checked (segments_checked),
		.segments_kept    (segments_kept)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("timed out with %0d results outstanding", pending);
		$display("line_clip_cohen_sutherland test failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off so the block backs up
	initial begin : result_sink
		int taken;
		int hold;
		taken = 0;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				taken++;
				if (taken == HOLD_AFTER)
					hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= snk_gaps && ($urandom_range(99) < 26);
			end
		end
	end

	function automatic lcs_pkg::lcs_in_t make_segment(input longint ax, input longint ay,
			input longint bx, input longint by);
		lcs_pkg::lcs_in_t s;
		s.ax = lcs_pkg::coord_t'(ax);
		s.ay = lcs_pkg::coord_t'(ay);
		s.bx = lcs_pkg::coord_t'(bx);
		s.by = lcs_pkg::coord_t'(by);
		return s;
	endfunction

	function automatic void add_edge_case(input lcs_pkg::lcs_in_t s);
		edge_cases = {edge_cases, s};
	endfunction

	function automatic longint fit_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// one coordinate aimed at the window span [lo, hi] (either order)
	function automatic longint pick_coord(input longint lo, input longint hi);
		longint      a, b, span;
		int unsigned mode;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		span = b - a + 1;
		mode = $urandom_range(99);
		if (mode < 25) begin
			// inside the span
			return a + longint'($urandom_range(b - a));
		end else if (mode < 55) begin
			// around the span, one width out on each side
			return fit_coord(a - span + longint'($urandom_range(3 * span - 1)));
		end else if (mode < 80) begin
			// anywhere
			return longint'(lcs_pkg::coord_t'($urandom));
		end else if (mode < 90) begin
			// on an edge or one step off it
			case ($urandom_range(5))
				0: return fit_coord(a - 1);
				1: return a;
				2: return fit_coord(a + 1);
				3: return fit_coord(b - 1);
				4: return b;
				default: return fit_coord(b + 1);
			endcase
		end else begin
			case ($urandom_range(3))
				0: return COORD_MIN;
				1: return COORD_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
	endfunction

	function automatic lcs_pkg::lcs_in_t random_segment();
		lcs_pkg::lcs_in_t s;
		s = make_segment(pick_coord(wx_lo, wx_hi), pick_coord(wy_lo, wy_hi),
			pick_coord(wx_lo, wx_hi), pick_coord(wy_lo, wy_hi));
		// now and then a vertical, horizontal or point segment
		if ($urandom_range(19) == 0)
			s.bx = s.ax;
		if ($urandom_range(19) == 0)
			s.by = s.ay;
		return s;
	endfunction

	// offer one segment and hold it until the transaction completes
	task automatic push_segment(input lcs_pkg::lcs_in_t s);
		if (src_gaps && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 40);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		// checker counts are registered, so they trail the channels
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all four window registers, starting at a random one
	task automatic set_window(input longint xl, input longint yl, input longint xh,
			input longint yh);
		longint                            vals[4];
		logic [lcs_pkg::CFG_IDX_WIDTH-1:0] regs[4];
		int                                first;
		int                                j;
		vals[0] = xl;
		vals[1] = yl;
		vals[2] = xh;
		vals[3] = yh;
		regs[0] = lcs_pkg::REG_X_MIN;
		regs[1] = lcs_pkg::REG_Y_MIN;
		regs[2] = lcs_pkg::REG_X_MAX;
		regs[3] = lcs_pkg::REG_Y_MAX;
		first = $urandom_range(3);
		for (int k = 0; k < 4; k++) begin
			j = (first + k) % 4;
			cfg_we <= 1'b1;
			cfg_index <= regs[j];
			cfg_data <= lcs_pkg::coord_t'(vals[j]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		wx_lo = longint'(lcs_pkg::coord_t'(xl));
		wy_lo = longint'(lcs_pkg::coord_t'(yl));
		wx_hi = longint'(lcs_pkg::coord_t'(xh));
		wy_hi = longint'(lcs_pkg::coord_t'(yh));
	endtask

	initial begin : stimulus
		longint r0, r1, r2, r3;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= lcs_pkg::REG_X_MIN;
		cfg_data <= '0;
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
		wx_lo = lcs_pkg::WIN_LO_RST;
		wy_lo = lcs_pkg::WIN_LO_RST;
		wx_hi = lcs_pkg::WIN_HI_RST;
		wy_hi = lcs_pkg::WIN_HI_RST;

		// directed segments against the reset window of +-2048
		add_edge_case(make_segment(0, 0, 1000, -1000));         // both inside
		add_edge_case(make_segment(-4000, 0, -3000, 100));      // both left
		add_edge_case(make_segment(0, 3000, 100, 4000));        // both above
		add_edge_case(make_segment(-4000, 0, 4000, 0));         // horizontal through
		add_edge_case(make_segment(0, -4000, 0, 4000));         // vertical through
		add_edge_case(make_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
		add_edge_case(make_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
		add_edge_case(make_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		add_edge_case(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		add_edge_case(make_segment(0, 0, 0, 0));                // inside point
		add_edge_case(make_segment(2048, 2048, 2048, 2048));    // point on the corner
		add_edge_case(make_segment(0, 0, 500, 5000));           // b through top
		add_edge_case(make_segment(0, 0, -700, -6000));         // b through bottom
		add_edge_case(make_segment(0, 0, 9000, 1300));          // b through right
		add_edge_case(make_segment(0, 0, -9000, -1300));        // b through left
		add_edge_case(make_segment(5000, 5000, 0, 0));          // a outside at a corner
		add_edge_case(make_segment(-4000, 1000, -1000, 4000));  // passes by the corner
		add_edge_case(make_segment(-2048, -4000, -2048, 4000)); // along the left edge
		add_edge_case(make_segment(2049, 0, 2049, 100));        // one step outside
		add_edge_case(make_segment(COORD_MIN, 0, COORD_MAX, 1));
		add_edge_case(make_segment(0, COORD_MIN, 1, COORD_MAX));
		add_edge_case(make_segment(-2049, -2049, 2049, 2049));
		add_edge_case(make_segment(-3000, 2500, 3000, -2600));  // clips both ends twice

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (edge_cases[i])
			push_segment(edge_cases[i]);

		for (int w = 0; w < NUM_WINDOWS; w++) begin
			// window 0 keeps the reset values
			if (w != 0)
				wait_drained();
			case (w)
				1: set_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX); // whole plane
				2: set_window(100, -100, 100, -100);                       // single point
				3: begin
					// random proper window
					r0 = longint'(lcs_pkg::coord_t'($urandom));
					r1 = longint'(lcs_pkg::coord_t'($urandom));
					r2 = longint'(lcs_pkg::coord_t'($urandom));
					r3 = longint'(lcs_pkg::coord_t'($urandom));
					set_window((r0 < r1) ? r0 : r1, (r2 < r3) ? r2 : r3,
						(r0 < r1) ? r1 : r0, (r2 < r3) ? r3 : r2);
				end
				4: set_window(3000, 2000, -3000, -1000);                   // inverted
				5: set_window(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN); // fully inverted
				6: set_window(COORD_MIN, 20000, -30000, COORD_MAX);        // corner of the plane
				7: set_window(longint'(lcs_pkg::coord_t'($urandom)),
					longint'(lcs_pkg::coord_t'($urandom)),
					longint'(lcs_pkg::coord_t'($urandom)),
					longint'(lcs_pkg::coord_t'($urandom)));
				default: ;
			endcase
			// one window runs back to back with no idling on either side
			src_gaps = (w != 3);
			snk_gaps = (w != 3);
			for (int i = 0; i < RANDOM_PER_WINDOW; i++) begin
				// sender waits out every result once mid-window
				if (w == 5 && i == RANDOM_PER_WINDOW / 2)
					wait_drained();
				push_segment(random_segment());
			end
		end
		wait_drained();

		$display("clipped %0d segments, %0d kept, over %0d window settings",
			segments_checked, segments_kept, NUM_WINDOWS);
		$display("windows: reset, whole plane, point, inverted, corner and random; stalls on both sides");
		if (fail_count == 0 && pending == 0)
			$display("line_clip_cohen_sutherland test passed");
		else
			$display("line_clip_cohen_sutherland test failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_div.sv
rtl/lcs_dp.sv
rtl/lcs_ctrl.sv
rtl/line_clip_cohen_sutherland.sv
bench/line_clip_cohen_sutherland_checker.sv
bench/line_clip_cohen_sutherland_test.sv
